/* hw/rtl/lgge_pkg.sv */
// ----------------------------------------------------------------------------
// lgge_pkg
// Shared types and constants of the life grid generation engine.
// ----------------------------------------------------------------------------
package lgge_pkg;

   localparam int ROW_BITS_W  = 64;
   localparam int CELL_IDX_W  = 6;
   localparam int REGION_W    = 7;
   localparam int GENS_W      = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int COUNT_W     = 4;

   // item kinds
   localparam logic KIND_ACTIVATE = 1'b0;
   localparam logic KIND_TICK     = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_GENERATIONS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ACTIVE_ROWS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ACTIVE_COLS = 2'd2;

   // register reset values
   localparam logic [GENS_W-1:0]   GENS_RESET = 8'd1;
   localparam logic [REGION_W-1:0] ROWS_RESET = 7'd64;
   localparam logic [REGION_W-1:0] COLS_RESET = 7'd64;

   // B3/S23 neighbour counts
   localparam logic [COUNT_W-1:0] BIRTH_COUNT   = 4'd3;
   localparam logic [COUNT_W-1:0] SURVIVE_COUNT = 4'd2;

   // row cell operations
   localparam logic [1:0] CELL_HOLD  = 2'd0;
   localparam logic [1:0] CELL_SHIFT = 2'd1;
   localparam logic [1:0] CELL_SET   = 2'd2;
   localparam logic [1:0] CELL_CLIP  = 2'd3;

   typedef struct packed {
      logic [1:0]            op;
      logic [CELL_IDX_W-1:0] act_row;
      logic [CELL_IDX_W-1:0] act_col;
      logic [REGION_W-1:0]   rows;
   } cell_ctrl_type;

endpackage

/* hw/rtl/life_grid_generation_engine_unit.sv */
// ----------------------------------------------------------------------------
// life_grid_generation_engine_unit
// Game of Life (B3/S23) engine over a chain of row cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_* words: kind 0 activates cell (cell_row, cell_col) inside the active
//   region; kind 1 runs generations_per_tick generations, then returns one
//   rsp_* word per active row, row 0 first, rsp_last on the final row.
//   csr_* writes set generations_per_tick (0), active_rows (1), active_cols (2);
//   the user must make them only while the engine is idle; the engine does not enforce this.
// Operation:
//   A tick first clears cells outside the region, then, for each
//   generation, rotates the rows through the chain past the window logic,
//   then rotates them once more, sending the active rows one per cycle
//   unless rsp_stall holds a pending word.
//   req_stall is high while a tick is in progress.
// Reset: all cells dead, registers at 1, 64, 64, no word pending.
// Stall: rsp_stall with a word pending freezes the emission rotation and holds the word.
// ----------------------------------------------------------------------------
module life_grid_generation_engine_unit #(
   parameter int GRID_ROWS = 64,
   parameter int GRID_COLS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic [lgge_pkg::CELL_IDX_W-1:0]     req_cell_row,
   input  logic [lgge_pkg::CELL_IDX_W-1:0]     req_cell_col,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lgge_pkg::CELL_IDX_W-1:0]     rsp_row_index,
   output logic [lgge_pkg::ROW_BITS_W-1:0]     rsp_row_bits,
   output logic                                rsp_last,
   input  logic                                csr_we,
   input  logic [lgge_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lgge_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CNT_W = $clog2(GRID_ROWS);
   localparam logic [CNT_W-1:0] LAST_ROW = CNT_W'(GRID_ROWS - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_GEN   = 3'd1;
   localparam logic [2:0] ST_EMIT  = 3'd2;
   localparam logic [2:0] ST_ALIGN = 3'd3;

   logic [lgge_pkg::GENS_W-1:0]   gens_ff;
   logic [lgge_pkg::REGION_W-1:0] act_rows_ff, act_cols_ff;
   logic [lgge_pkg::REGION_W-1:0] rows_eff, cols_eff;
   logic [GRID_COLS-1:0]          col_mask;

   logic [2:0]                    state_ff, state_in;
   logic [CNT_W-1:0]              row_cnt_ff, row_cnt_in, row_cnt_wrap;
   logic [lgge_pkg::GENS_W-1:0]   gen_cnt_ff, gen_cnt_in;
   logic [lgge_pkg::REGION_W-1:0] k7;
   logic [GRID_COLS-1:0]          prev_ff;
   logic [GRID_COLS-1:0]          up_row, dn_row, life_row, feed_row;
   logic                          feed_new, rsp_load, rsp_free, act_ok;
   lgge_pkg::cell_ctrl_type       ctrl;

   logic [GRID_COLS-1:0]          row_q [GRID_ROWS];

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [lgge_pkg::CELL_IDX_W-1:0] rsp_row_index_ff;
   logic [lgge_pkg::ROW_BITS_W-1:0] rsp_row_bits_ff;
   logic                          rsp_last_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gens_ff     <= lgge_pkg::GENS_RESET;
         act_rows_ff <= lgge_pkg::ROWS_RESET;
         act_cols_ff <= lgge_pkg::COLS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            lgge_pkg::REG_GENERATIONS: gens_ff <= csr_wdata;
            lgge_pkg::REG_ACTIVE_ROWS: act_rows_ff <= csr_wdata[lgge_pkg::REGION_W-1:0];
            lgge_pkg::REG_ACTIVE_COLS: act_cols_ff <= csr_wdata[lgge_pkg::REGION_W-1:0];
            default: ;
         endcase
      end
   end

   assign rows_eff = (act_rows_ff > lgge_pkg::REGION_W'(GRID_ROWS))
                   ? lgge_pkg::REGION_W'(GRID_ROWS) : act_rows_ff;
   assign cols_eff = (act_cols_ff > lgge_pkg::REGION_W'(GRID_COLS))
                   ? lgge_pkg::REGION_W'(GRID_COLS) : act_cols_ff;

   always_comb begin
      for (int c = 0; c < GRID_COLS; c++) begin
         col_mask[c] = (lgge_pkg::REGION_W'(c) < cols_eff);
      end
   end

   // chain of row cells
   generate
      for (genvar i = 0; i < GRID_ROWS; i++) begin : g_row
         logic [GRID_COLS-1:0] shift_src;
         if (i == GRID_ROWS - 1) begin : g_tail
            assign shift_src = feed_row;
         end else begin : g_body
            assign shift_src = row_q[i+1];
         end
         lgge_row_cell #(
            .COLS  (GRID_COLS),
            .INDEX (i)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .col_mask (col_mask),
            .shift_in (shift_src),
            .row_out  (row_q[i])
         );
      end
   endgenerate

   // three-row window at the head of the chain
   assign k7     = lgge_pkg::REGION_W'(row_cnt_ff);
   assign up_row = (row_cnt_ff == '0) ? '0 : prev_ff;
   assign dn_row = ((k7 + 7'd1) < rows_eff) ? row_q[1] : '0;

   lgge_life_row #(
      .COLS (GRID_COLS)
   ) u_life (
      .up_row   (up_row),
      .mid_row  (row_q[0]),
      .dn_row   (dn_row),
      .col_mask (col_mask),
      .next_row (life_row)
   );

   assign feed_row = feed_new ? ((k7 < rows_eff) ? life_row : '0) : row_q[0];

   assign row_cnt_wrap = (row_cnt_ff == LAST_ROW) ? '0 : row_cnt_ff + CNT_W'(1);
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign act_ok       = ({1'b0, req_cell_row} < rows_eff)
                      && ({1'b0, req_cell_col} < cols_eff);

   always_comb begin
      state_in     = state_ff;
      row_cnt_in   = row_cnt_ff;
      gen_cnt_in   = gen_cnt_ff;
      feed_new     = 1'b0;
      rsp_load     = 1'b0;
      ctrl.op      = lgge_pkg::CELL_HOLD;
      ctrl.act_row = req_cell_row;
      ctrl.act_col = req_cell_col;
      ctrl.rows    = rows_eff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == lgge_pkg::KIND_ACTIVATE) begin
                  if (act_ok) begin
                     ctrl.op = lgge_pkg::CELL_SET;
                  end
               end else begin
                  ctrl.op    = lgge_pkg::CELL_CLIP;
                  row_cnt_in = '0;
                  gen_cnt_in = '0;
                  if ((rows_eff == '0) || (cols_eff == '0)) begin
                     state_in = ST_IDLE;
                  end else if (gens_ff == '0) begin
                     state_in = ST_EMIT;
                  end else begin
                     state_in = ST_GEN;
                  end
               end
            end
         end
         ST_GEN: begin
            ctrl.op    = lgge_pkg::CELL_SHIFT;
            feed_new   = 1'b1;
            row_cnt_in = row_cnt_wrap;
            if (row_cnt_ff == LAST_ROW) begin
               gen_cnt_in = gen_cnt_ff + 8'd1;
               if ((gen_cnt_ff + 8'd1) == gens_ff) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_load   = 1'b1;
               ctrl.op    = lgge_pkg::CELL_SHIFT;
               row_cnt_in = row_cnt_wrap;
               if ((k7 + 7'd1) == rows_eff) begin
                  state_in = (row_cnt_ff == LAST_ROW) ? ST_IDLE : ST_ALIGN;
               end
            end
         end
         ST_ALIGN: begin
            ctrl.op    = lgge_pkg::CELL_SHIFT;
            row_cnt_in = row_cnt_wrap;
            if (row_cnt_ff == LAST_ROW) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         row_cnt_ff <= '0;
         gen_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         row_cnt_ff <= row_cnt_in;
         gen_cnt_ff <= gen_cnt_in;
      end
   end

   // hold the row above the window
   always_ff @(posedge clock) begin
      if (state_ff == ST_GEN) begin
         prev_ff <= row_q[0];
      end
   end

   // output word register
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_row_index_ff <= lgge_pkg::CELL_IDX_W'(row_cnt_ff);
         rsp_row_bits_ff  <= lgge_pkg::ROW_BITS_W'(row_q[0]);
         rsp_last_ff      <= ((k7 + 7'd1) == rows_eff);
      end
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_index = rsp_row_index_ff;
   assign rsp_row_bits  = rsp_row_bits_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef ASSERT_OFF
   a_idle_aligned: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> row_cnt_ff == '0)
      else $error("row chain not realigned on return to idle");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      lgge_pkg::REGION_W'(row_cnt_ff) < lgge_pkg::REGION_W'(GRID_ROWS))
      else $error("row counter beyond grid");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EMIT)
      else $error("row word raised outside emission");
`endif

endmodule

/* hw/rtl/lgge_row_cell.sv */
// ----------------------------------------------------------------------------
// lgge_row_cell
// One grid row: holds its cells, shifts from its neighbour, sets a cell
// on activate and clears itself outside the active region.
// ----------------------------------------------------------------------------
module lgge_row_cell #(
   parameter int COLS  = 64,
   parameter int INDEX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lgge_pkg::cell_ctrl_type ctrl,
   input  logic [COLS-1:0]        col_mask,
   input  logic [COLS-1:0]        shift_in,
   output logic [COLS-1:0]        row_out
);

   logic [COLS-1:0] row_ff;
   logic [COLS-1:0] row_in;
   logic            row_hit;
   logic            beyond;

   assign row_hit = (ctrl.act_row == lgge_pkg::CELL_IDX_W'(INDEX));
   assign beyond  = (lgge_pkg::REGION_W'(INDEX) >= ctrl.rows);

   always_comb begin
      row_in = row_ff;
      case (ctrl.op)
         lgge_pkg::CELL_HOLD: row_in = row_ff;
         lgge_pkg::CELL_SHIFT: row_in = shift_in;
         lgge_pkg::CELL_SET: begin
            for (int c = 0; c < COLS; c++) begin
               if (row_hit && (ctrl.act_col == lgge_pkg::CELL_IDX_W'(c))) begin
                  row_in[c] = 1'b1;
               end
            end
         end
         lgge_pkg::CELL_CLIP: row_in = beyond ? '0 : (row_ff & col_mask);
         default: row_in = row_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row_out = row_ff;

endmodule

/* hw/rtl/lgge_life_row.sv */
// ----------------------------------------------------------------------------
// lgge_life_row
// Next state of one row from the three-row window under rule B3/S23.
// ----------------------------------------------------------------------------
module lgge_life_row #(
   parameter int COLS = 64
) (
   input  logic [COLS-1:0] up_row,
   input  logic [COLS-1:0] mid_row,
   input  logic [COLS-1:0] dn_row,
   input  logic [COLS-1:0] col_mask,
   output logic [COLS-1:0] next_row
);

   logic [COLS-1:0] up_l, up_r, mid_l, mid_r, dn_l, dn_r;
   logic [COLS-1:0] rule;

   // bit c of *_l is column c-1, of *_r is column c+1
   assign up_l  = {up_row[COLS-2:0], 1'b0};
   assign up_r  = {1'b0, up_row[COLS-1:1]};
   assign mid_l = {mid_row[COLS-2:0], 1'b0};
   assign mid_r = {1'b0, mid_row[COLS-1:1]};
   assign dn_l  = {dn_row[COLS-2:0], 1'b0};
   assign dn_r  = {1'b0, dn_row[COLS-1:1]};

   always_comb begin
      logic [lgge_pkg::COUNT_W-1:0] n;
      for (int c = 0; c < COLS; c++) begin
         n = lgge_pkg::COUNT_W'(up_l[c]) + lgge_pkg::COUNT_W'(up_row[c])
           + lgge_pkg::COUNT_W'(up_r[c]) + lgge_pkg::COUNT_W'(mid_l[c])
           + lgge_pkg::COUNT_W'(mid_r[c]) + lgge_pkg::COUNT_W'(dn_l[c])
           + lgge_pkg::COUNT_W'(dn_row[c]) + lgge_pkg::COUNT_W'(dn_r[c]);
         rule[c] = (n == lgge_pkg::BIRTH_COUNT)
                || ((n == lgge_pkg::SURVIVE_COUNT) && mid_row[c]);
      end
   end

   assign next_row = rule & col_mask;

endmodule
